### hw/rtl/s2d_pkg.sv
package s2d_pkg;

  // widths of the result fields
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned DIGIT_W = 4;

  // ascii codes
  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'd45;
  localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'd48;

  // digits at or above this value get the add-3 correction before a shift
  localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

endpackage

### hw/rtl/s2d_if.sv
// integer request channel
interface s2d_value_if #(
  parameter int unsigned VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// character request channel
interface s2d_char_if;
  logic                          valid;
  logic                          ready;
  logic [s2d_pkg::CHAR_W-1:0]    character;
  logic [s2d_pkg::POS_W-1:0]     position;
  logic                          last;

  modport source (output valid, output character, output position, output last, input ready);
  modport sink   (input valid, input character, input position, input last, output ready);
endinterface

### hw/rtl/signed_int_to_decimal_ascii.sv
// Prints one two's complement integer of VALUE_BITS bits as decimal ASCII text, most
// significant digit first, one character per output request with its 1-based position
// (4 bits, wraps for texts longer than 15) and a last flag. Negative values get a leading
// '-', zero prints "0", and there are no leading zeros. One integer is handled at a time:
// after a request is taken, a bit-serial double-dabble converter shifts the magnitude
// into a BCD register, then the unused leading zero digit slots are dropped one at a
// time, then one character leaves per cycle through an output register while the sink
// keeps up. At VALUE_BITS = 32 there are ten digit slots. The next integer is taken in
// the cycle after the last character is registered.
module signed_int_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  s2d_value_if.sink      in_i,
  s2d_char_if.source     out_o
);

  localparam int unsigned NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned BCD_W      = NUM_DIGITS * s2d_pkg::DIGIT_W;
  localparam int unsigned CNT_W      = $clog2(VALUE_BITS);
  localparam int unsigned REM_W      = $clog2(NUM_DIGITS + 1);
  localparam int unsigned DW         = s2d_pkg::DIGIT_W;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);
  localparam logic [REM_W-1:0] REM_FULL = REM_W'(NUM_DIGITS);
  localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);

  s2d_pkg::state_e state_q, state_d;

  logic [VALUE_BITS-1:0]     mag_q, mag_d;
  logic [BCD_W-1:0]          bcd_q, bcd_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [REM_W-1:0]          rem_q, rem_d;
  logic                      sign_q, sign_d;
  logic [s2d_pkg::POS_W-1:0] pos_q, pos_d;

  logic                        ovalid_q, ovalid_d;
  logic [s2d_pkg::CHAR_W-1:0]  ochar_q, ochar_d;
  logic [s2d_pkg::POS_W-1:0]   opos_q, opos_d;
  logic                        olast_q, olast_d;

  logic                  in_fire;
  logic                  slot_free;
  logic [BCD_W-1:0]      bcd_adj;
  logic [DW-1:0]         top_digit;

  assign in_i.ready = (state_q == s2d_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign slot_free  = !ovalid_q || out_o.ready;
  assign top_digit  = bcd_q[BCD_W-1 -: DW];

  // add-3 correction on every bcd digit ahead of the shift
  always_comb begin
    logic [DW-1:0] d;
    bcd_adj = bcd_q;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = bcd_q[i*DW +: DW];
      if (d >= s2d_pkg::DABBLE_MIN) begin
        bcd_adj[i*DW +: DW] = d + s2d_pkg::DABBLE_ADD;
      end
    end
  end

  // sequencer: load, convert, drop leading zeros, emit
  always_comb begin
    state_d  = state_q;
    mag_d    = mag_q;
    bcd_d    = bcd_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    sign_d   = sign_q;
    pos_d    = pos_q;
    ovalid_d = ovalid_q && !out_o.ready;
    ochar_d  = ochar_q;
    opos_d   = opos_q;
    olast_d  = olast_q;

    unique case (state_q)
      s2d_pkg::ST_IDLE: begin
        if (in_fire) begin
          sign_d  = in_i.value[VALUE_BITS-1];
          mag_d   = in_i.value[VALUE_BITS-1] ? (~in_i.value + VALUE_BITS'(1)) : in_i.value;
          bcd_d   = '0;
          cnt_d   = '0;
          rem_d   = REM_FULL;
          pos_d   = '0;
          state_d = s2d_pkg::ST_CONV;
        end
      end
      s2d_pkg::ST_CONV: begin
        bcd_d = {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
        mag_d = {mag_q[VALUE_BITS-2:0], 1'b0};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = s2d_pkg::ST_SKIP;
        end
      end
      s2d_pkg::ST_SKIP: begin
        if (top_digit == '0 && rem_q != REM_ONE) begin
          bcd_d = {bcd_q[BCD_W-DW-1:0], {DW{1'b0}}};
          rem_d = rem_q - REM_W'(1);
        end else begin
          state_d = s2d_pkg::ST_EMIT;
        end
      end
      s2d_pkg::ST_EMIT: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          pos_d    = pos_q + s2d_pkg::POS_W'(1);
          opos_d   = pos_q + s2d_pkg::POS_W'(1);
          if (sign_q) begin
            sign_d  = 1'b0;
            ochar_d = s2d_pkg::MINUS_CHAR;
            olast_d = 1'b0;
          end else begin
            ochar_d = s2d_pkg::ZERO_CHAR + s2d_pkg::CHAR_W'(top_digit);
            olast_d = (rem_q == REM_ONE);
            bcd_d   = {bcd_q[BCD_W-DW-1:0], {DW{1'b0}}};
            rem_d   = rem_q - REM_W'(1);
            if (rem_q == REM_ONE) begin
              state_d = s2d_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = s2d_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= s2d_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
      rem_q    <= '0;
      sign_q   <= 1'b0;
      pos_q    <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      sign_q   <= sign_d;
      pos_q    <= pos_d;
    end
  end

  // datapath and output payload
  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    bcd_q   <= bcd_d;
    ochar_q <= ochar_d;
    opos_q  <= opos_d;
    olast_q <= olast_d;
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.character = ochar_q;
  assign out_o.position  = opos_q;
  assign out_o.last      = olast_q;

  // a taken request always starts a conversion
  a_load_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == s2d_pkg::ST_CONV)
    else $error("request did not start a conversion");

  // conversion moves on to the skip state after its last shift
  a_conv_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == s2d_pkg::ST_CONV && cnt_q == CNT_LAST) |=> state_q == s2d_pkg::ST_SKIP)
    else $error("conversion length wrong");

  // digit slots never run out before the last character
  a_rem_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == s2d_pkg::ST_SKIP || state_q == s2d_pkg::ST_EMIT) |-> rem_q != '0)
    else $error("digit count underflow");

  // converted digits are valid decimal
  a_bcd_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == s2d_pkg::ST_SKIP || state_q == s2d_pkg::ST_EMIT) |->
      top_digit <= s2d_pkg::DIGIT_MAX)
    else $error("bcd digit out of range");

  // a minus sign is first and never last
  a_minus_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ochar_q == s2d_pkg::MINUS_CHAR) |->
      (opos_q == s2d_pkg::POS_W'(1) && !olast_q))
    else $error("minus sign misplaced");

endmodule

### test/signed_int_to_decimal_ascii_test.sv
module signed_int_to_decimal_ascii_test;

  localparam int unsigned VALUE_BITS = 32;
  localparam int RAND_N      = 420;
  localparam int QUIET_N     = 60;
  localparam int PRESSURE_AT = 150;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 60;
  localparam int LIMIT       = 400000;
  localparam int TEXT_MAX    = 11;

  // one expected character of the decimal text
  typedef struct packed {
    logic [s2d_pkg::CHAR_W-1:0] character;
    logic [s2d_pkg::POS_W-1:0]  position;
    logic                       last;
  } text_char_t;

  // one directed row: text of zero means the predictor supplies the answer
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [TEXT_MAX*8-1:0] text;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  s2d_value_if #(.VALUE_BITS(VALUE_BITS)) value_bus ();
  s2d_char_if char_bus ();

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (value_bus),
    .out_o (char_bus)
  );

  text_char_t text_exp_q[$];
  dir_row_t   dir_rows[$];
  text_char_t got_char;
  text_char_t want_char;
  int         fail_cnt = 0;
  int         cycle_cnt = 0;
  bit         no_idle = 1'b0;
  bit         hold_off_req = 1'b0;

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // predictor: decimal text of one signed integer, sign first, no leading zeros
  task automatic predict_text(input logic [VALUE_BITS-1:0] v);
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]            digs[20];
    int                    nd;
    int                    total;
    int                    k;
    text_char_t            c;
    neg = v[VALUE_BITS-1];
    mag = neg ? (~v + 1'b1) : v;
    nd = 0;
    if (mag == 0) begin
      digs[0] = 4'd0;
      nd = 1;
    end
    while (mag != 0) begin
      digs[nd] = 4'(mag % 10);
      mag = mag / 10;
      nd++;
    end
    total = nd + (neg ? 1 : 0);
    k = 0;
    if (neg) begin
      c.character = s2d_pkg::MINUS_CHAR;
      c.position  = s2d_pkg::POS_W'(1);
      c.last      = (total == 1);
      text_exp_q.push_back(c);
      k = 1;
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.character = s2d_pkg::ZERO_CHAR + s2d_pkg::CHAR_W'(digs[i]);
      c.position  = s2d_pkg::POS_W'(k + 1);
      c.last      = (k + 1 == total);
      text_exp_q.push_back(c);
      k++;
    end
  endtask

  // offer one integer request, with an optional idle burst first
  task automatic offer_value(input logic [VALUE_BITS-1:0] v, input logic [TEXT_MAX*8-1:0] text);
    int         gap;
    int         len;
    text_char_t c;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      value_bus.valid <= 1'b0;
      value_bus.value <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    value_bus.valid <= 1'b1;
    value_bus.value <= v;
    do @(posedge clk_i); while (!value_bus.ready);
    if (text == 0) begin
      predict_text(v);
    end else begin
      // typed-in text is right-justified, first character in the highest used byte
      len = 0;
      for (int b = 0; b < TEXT_MAX; b++) begin
        if (text[b*8 +: 8] != 8'd0) len = b + 1;
      end
      for (int k = 0; k < len; k++) begin
        c.character = text[(len-1-k)*8 +: 8];
        c.position  = s2d_pkg::POS_W'(k + 1);
        c.last      = (k == len - 1);
        text_exp_q.push_back(c);
      end
    end
  endtask

  task automatic add_row(input logic [VALUE_BITS-1:0] v, input logic [TEXT_MAX*8-1:0] text);
    dir_row_t r;
    r.value = v;
    r.text  = text;
    dir_rows.push_back(r);
  endtask

  // character receiver: random stalls, one long hold-off on request
  initial begin
    int burst;
    char_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        char_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 13);
        char_bus.ready <= 1'b0;
        repeat (burst - 1) @(posedge clk_i);
      end else begin
        char_bus.ready <= 1'b1;
      end
    end
  end

  // compare each accepted character with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && char_bus.valid && char_bus.ready) begin
      got_char.character = char_bus.character;
      got_char.position  = char_bus.position;
      got_char.last      = char_bus.last;
      if (text_exp_q.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual char %0d pos %0d last %0b",
                 $time, got_char.character, got_char.position, got_char.last);
        fail_cnt++;
      end else begin
        want_char = text_exp_q.pop_front();
        if (got_char.character !== want_char.character) begin
          $display("%0t: character mismatch: expected %0d, actual %0d",
                   $time, want_char.character, got_char.character);
          fail_cnt++;
        end
        if (got_char.position !== want_char.position) begin
          $display("%0t: position mismatch: expected %0d, actual %0d",
                   $time, want_char.position, got_char.position);
          fail_cnt++;
        end
        if (got_char.last !== want_char.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b",
                   $time, want_char.last, got_char.last);
          fail_cnt++;
        end
      end
    end
  end

  // integer sender and run control
  initial begin
    logic [VALUE_BITS-1:0] v;
    longint unsigned       mag64;
    longint unsigned       lim;
    int                    n;
    value_bus.valid <= 1'b0;
    value_bus.value <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: zero, single digits, sign handling, extremes, digit patterns
    add_row(32'd0, "0");
    add_row(32'd1, "1");
    add_row(-32'sd1, "-1");
    add_row(32'd9, "9");
    add_row(32'd10, "10");
    add_row(-32'sd10, "-10");
    add_row(-32'sd7, "-7");
    add_row(32'd2147483647, "2147483647");
    add_row(32'h8000_0000, "-2147483648");
    add_row(32'h8000_0001, "-2147483647");
    add_row(32'd1000000000, "1000000000");
    add_row(-32'sd1000000000, "-1000000000");
    add_row(32'd999999999, "999999999");
    add_row(-32'sd999999999, "-999999999");
    add_row(32'd100, '0);
    add_row(32'd12345, '0);
    add_row(-32'sd54321, '0);
    add_row(32'h5555_5555, '0);
    add_row(32'hAAAA_AAAA, '0);
    add_row(32'h0F0F_0F0F, '0);
    add_row(32'hF0F0_F0F0, '0);
    add_row(32'd2000000000, '0);
    add_row(32'd1073741824, '0);
    foreach (dir_rows[i]) offer_value(dir_rows[i].value, dir_rows[i].text);

    // random integers: full range, small values, chosen digit counts, near powers of ten
    for (int i = 0; i < RAND_N; i++) begin
      if (i == PRESSURE_AT) hold_off_req = 1'b1;
      if (i >= RAND_N - QUIET_N) no_idle = 1'b1;
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = $urandom_range(0, 199) - 100;
        2: begin
          n = $urandom_range(1, 10);
          lim = 1;
          repeat (n) lim = lim * 10;
          mag64 = {$urandom, $urandom} % lim;
          v = mag64[31:0];
          if ($urandom_range(0, 1) == 1) v = -v;
        end
        default: begin
          n = $urandom_range(0, 9);
          lim = 1;
          repeat (n) lim = lim * 10;
          mag64 = lim + $urandom_range(0, 2) - 1;
          v = mag64[31:0];
          if ($urandom_range(0, 1) == 1) v = -v;
        end
      endcase
      offer_value(v, '0);
    end
    value_bus.valid <= 1'b0;

    // drain, then give the block time to show any stray characters
    while (text_exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
